/* rtl/dda_pkg.sv */
// Package for the DDA line rasterizer: widths, op codes, FSM state type,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS = 9;
    localparam int FRAC_BITS  = 16;

    localparam int POS_W  = COORD_BITS + FRAC_BITS;   // unsigned position
    localparam int STEP_W = FRAC_BITS + 2;            // signed increment
    localparam int QUO_W  = FRAC_BITS + 1;            // quotient magnitude
    localparam int REM_W  = COORD_BITS + 1;           // partial remainder
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS);
    localparam logic [POS_W-1:0] POS_HALF = POS_W'(1) << (FRAC_BITS - 1);

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic take;      // input transaction accepted this cycle
        logic div_run;   // divider iterates this cycle
    } cmd_t;

    typedef struct packed {
        logic start_nz;  // pending item is a start with nonzero span
        logic div_last;  // divider on its final iteration
        logic out_full;  // output register holds an untaken result
    } status_t;

endpackage

`default_nettype wire

/* rtl/dda_ctrl.sv */
// Controller FSM for the DDA line rasterizer: input handshake and divider
// sequencing. Depends on dda_pkg.
`default_nettype none

module dda_ctrl
    import dda_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire logic    m_axis_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE) && (!status.out_full || m_axis_tready);
        cmd.take      = s_axis_tready && s_axis_tvalid;
        cmd.div_run   = (state_reg == ST_DIV);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take && status.start_nz)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dda_datapath.sv */
// Datapath for the DDA line rasterizer: position accumulators, two
// restoring dividers for the increments, output register. Depends on dda_pkg.
`default_nettype none

module dda_datapath
    import dda_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    input  wire logic                  m_axis_tready,
    output logic                       m_axis_tvalid,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser
);

    logic [COORD_BITS-1:0] xs, ys, xe, ye;
    logic [REM_W-1:0]      dx, dy, dx_neg, dy_neg;
    logic [COORD_BITS-1:0] ax, ay, steps_in;
    logic                  is_start;

    logic [POS_W-1:0]      pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [STEP_W-1:0]     step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic [COORD_BITS-1:0] steps_left_reg, steps_left_next;
    logic                  line_active_reg, line_active_next;

    logic [COORD_BITS-1:0] div_steps_reg, div_steps_next;
    logic [REM_W-1:0]      rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QUO_W-1:0]      quo_x_reg, quo_x_next, quo_y_reg, quo_y_next;
    logic                  neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_pv_reg, out_pv_next;

    logic [POS_W-1:0]      sum_x, sum_y, rnd_x, rnd_y;
    logic                  last_adv;
    logic [REM_W-1:0]      div_den, diff_x, diff_y;
    logic                  d_x, d_y;
    logic [QUO_W-1:0]      q_fin_x, q_fin_y;

    assign xs = s_axis_tdata[COORD_BITS-1:0];
    assign ys = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign xe = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign ye = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    always_comb
    begin
        is_start = (s_axis_tuser == OP_START);
        dx       = {1'b0, xe} - {1'b0, xs};
        dy       = {1'b0, ye} - {1'b0, ys};
        dx_neg   = REM_W'(0) - dx;
        dy_neg   = REM_W'(0) - dy;
        ax       = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay       = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        steps_in = (ax > ay) ? ax : ay;
    end

    // advance: accumulate, then round half up
    always_comb
    begin
        sum_x    = pos_x_reg + {{(POS_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
        sum_y    = pos_y_reg + {{(POS_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
        rnd_x    = sum_x + POS_HALF;
        rnd_y    = sum_y + POS_HALF;
        last_adv = (steps_left_reg == COORD_BITS'(1));
    end

    // one quotient bit per cycle on each axis
    always_comb
    begin
        div_den = {1'b0, div_steps_reg};
        d_x     = (rem_x_reg >= div_den);
        d_y     = (rem_y_reg >= div_den);
        diff_x  = rem_x_reg - (d_x ? div_den : REM_W'(0));
        diff_y  = rem_y_reg - (d_y ? div_den : REM_W'(0));
        q_fin_x = {quo_x_reg[QUO_W-2:0], d_x};
        q_fin_y = {quo_y_reg[QUO_W-2:0], d_y};
    end

    always_comb
    begin
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        steps_left_next  = steps_left_reg;
        line_active_next = line_active_reg;
        div_steps_next   = div_steps_reg;
        rem_x_next       = rem_x_reg;
        rem_y_next       = rem_y_reg;
        quo_x_next       = quo_x_reg;
        quo_y_next       = quo_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        cnt_next         = cnt_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_last_next    = out_last_reg;
        out_pv_next      = out_pv_reg;

        if (cmd.take)
        begin
            if (is_start)
            begin
                pos_x_next       = {xs, {FRAC_BITS{1'b0}}};
                pos_y_next       = {ys, {FRAC_BITS{1'b0}}};
                step_x_next      = '0;
                step_y_next      = '0;
                steps_left_next  = steps_in;
                line_active_next = (steps_in != '0);
                div_steps_next   = steps_in;
                rem_x_next       = {1'b0, ax};
                rem_y_next       = {1'b0, ay};
                quo_x_next       = '0;
                quo_y_next       = '0;
                neg_x_next       = dx[COORD_BITS];
                neg_y_next       = dy[COORD_BITS];
                cnt_next         = '0;
                out_x_next       = xs;
                out_y_next       = ys;
                out_last_next    = (steps_in == '0);
                out_pv_next      = 1'b1;
            end
            else if (line_active_reg)
            begin
                pos_x_next       = sum_x;
                pos_y_next       = sum_y;
                steps_left_next  = steps_left_reg - COORD_BITS'(1);
                line_active_next = !last_adv;
                out_x_next       = rnd_x[POS_W-1:FRAC_BITS];
                out_y_next       = rnd_y[POS_W-1:FRAC_BITS];
                out_last_next    = last_adv;
                out_pv_next      = 1'b1;
            end
            else
            begin
                out_x_next    = '0;
                out_y_next    = '0;
                out_last_next = 1'b0;
                out_pv_next   = 1'b0;
            end
        end

        if (cmd.div_run)
        begin
            rem_x_next = {diff_x[COORD_BITS-1:0], 1'b0};
            rem_y_next = {diff_y[COORD_BITS-1:0], 1'b0};
            quo_x_next = q_fin_x;
            quo_y_next = q_fin_y;
            cnt_next   = cnt_reg + CNT_W'(1);
            if (status.div_last)
            begin
                step_x_next = neg_x_reg ? STEP_W'(0) - {1'b0, q_fin_x} : {1'b0, q_fin_x};
                step_y_next = neg_y_reg ? STEP_W'(0) - {1'b0, q_fin_y} : {1'b0, q_fin_y};
            end
        end

        if (cmd.take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            steps_left_reg  <= '0;
            line_active_reg <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            steps_left_reg  <= steps_left_next;
            line_active_reg <= line_active_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_steps_reg <= div_steps_next;
        rem_x_reg     <= rem_x_next;
        rem_y_reg     <= rem_y_next;
        quo_x_reg     <= quo_x_next;
        quo_y_reg     <= quo_y_next;
        neg_x_reg     <= neg_x_next;
        neg_y_reg     <= neg_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_last_reg  <= out_last_next;
        out_pv_reg    <= out_pv_next;
    end

    always_comb
    begin
        status.start_nz = is_start && (steps_in != '0);
        status.div_last = (cnt_reg == DIV_LAST);
        status.out_full = out_valid_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2*COORD_BITS){1'b0}}, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_pv_reg;

endmodule

`default_nettype wire

/* rtl/dda_line_rasterizer_core.sv */
// Top level of the DDA line rasterizer: joins controller and datapath.
// Depends on dda_pkg, dda_ctrl, dda_datapath.
//
//  channel  dir  tdata (low bit up)                      tuser        tlast
//  s_axis   in   x_start, y_start, x_end, y_end, zeros   op           -
//  m_axis   out  pixel_x, pixel_y, zeros                 pixel_valid  last_pixel
//
// Advance: one transaction per cycle unless m_axis stalls; result registered for the next cycle.
// Start with nonzero span: accepted, then the bit-serial dividers hold
// s_axis_tready low until all QUO_W quotient bits are formed.
// Zero-length start: no divide, the FSM stays idle.
// Reset clears the FSM, line state and output valid; m_axis stalls hold
// the output register and back-pressure the input.
`default_nettype none

module dda_line_rasterizer_core
    import dda_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // x_start, y_start, x_end, y_end
    input  wire logic                  s_axis_tuser,   // op
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // pixel_x, pixel_y
    output logic                       m_axis_tlast,   // last_pixel
    output logic                       m_axis_tuser    // pixel_valid
);

    cmd_t    cmd;
    status_t status;

    dda_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    dda_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* rtl/dda_checker.sv */
// Port-level assertions for dda_line_rasterizer_core, bound to the top.
// Depends on dda_pkg.
`default_nettype none

module dda_checker
    import dda_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic                  s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic                  m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed under stall");

    // every accepted transaction yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("missing result");

    // start pixel echoes the first endpoint
    a_start_pix: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_START |=>
            m_axis_tuser
            && m_axis_tdata[2*COORD_BITS-1:0] == $past(s_axis_tdata[2*COORD_BITS-1:0]))
        else $error("start pixel mismatch");

    // no-line advance result is all zero
    a_idle_adv: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
        else $error("invalid pixel carries data");

    // nonzero horizontal span: divider busy, line not last
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_START
        && s_axis_tdata[COORD_BITS-1:0] != s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS] |=>
            !s_axis_tready && !m_axis_tlast)
        else $error("divider not engaged");

endmodule

bind dda_line_rasterizer_core dda_checker u_dda_checker (.*);

`default_nettype wire
